@@ design/assert_macros.svh @@
// assertion macros shared by the tree index math rtl
// no dependencies; included by modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge outside reset
`define A_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: check failed");
// antecedent implies consequent in the same cycle
`define A_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// antecedent implies consequent in the next cycle
`define A_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define A_ALWAYS(lbl, clk, rst_n, expr)
`define A_IMPLIES(lbl, clk, rst_n, ante, cons)
`define A_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/lbtm_pkg.sv @@
// shared types, constants and index functions for the tree index math unit
// no dependencies
`timescale 1ns / 1ps

package lbtm_pkg;

  localparam int NODE_W    = 17;
  localparam int LEAF_BITS = 16;
  localparam logic [NODE_W-1:0] LEAF_CAP =
    NODE_W'((LEAF_BITS >= 16) ? 65536 : (1 << LEAF_BITS));

  typedef enum logic [2:0] {
    OP_LEVEL   = 3'd0,
    OP_LEFT    = 3'd1,
    OP_RIGHT   = 3'd2,
    OP_PARENT  = 3'd3,
    OP_SIBLING = 3'd4,
    OP_ROOT    = 3'd5,
    OP_PATH    = 3'd6,
    OP_COPATH  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PFIX,
    ST_SFIX
  } state_t;

  // working register updates
  typedef enum logic [1:0] {
    P_HOLD,
    P_UP_X,
    P_SET_X,
    P_UP_P
  } p_op_t;

  typedef enum logic [1:0] {
    S_HOLD,
    S_SIB,
    S_RIGHT_X,
    S_LEFT
  } s_op_t;

  // result value source
  typedef enum logic [2:0] {
    V_ROOT,
    V_ZERO,
    V_LEVEL,
    V_LEFT,
    V_P,
    V_S
  } vsel_t;

  typedef struct packed {
    logic  load;
    logic  x_from_p;
    p_op_t p_op;
    s_op_t s_op;
    logic  emit;
    vsel_t vsel;
    logic  last;
    logic  empty;
    logic  oor;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic x_oor;
    logic x_is_root;
    logic p_ge_w;
    logic p_is_root;
    logic s_ge_w;
    logic out_busy;
  } dp_stat_t;

  // one-hot of the lowest zero bit, one bit wider than a node index
  function automatic logic [NODE_W:0] low_zero(input logic [NODE_W-1:0] x);
    logic [NODE_W:0] xe;
    xe = {1'b0, x};
    return ~xe & (xe + 1'b1);
  endfunction

  function automatic logic [NODE_W-1:0] level_of(input logic [NODE_W-1:0] x);
    logic [NODE_W:0]   t;
    logic [NODE_W-1:0] lvl;
    t   = low_zero(x);
    lvl = '0;
    for (int i = 0; i <= NODE_W; i++) begin
      if (t[i]) lvl = lvl | NODE_W'(i);
    end
    return lvl;
  endfunction

  function automatic logic [NODE_W-1:0] left_of(input logic [NODE_W-1:0] x);
    logic [NODE_W:0] t;
    t = low_zero(x);
    if (t[0]) return x;
    return x ^ t[NODE_W:1];
  endfunction

  // right child before the leftward repair
  function automatic logic [NODE_W-1:0] raw_right(input logic [NODE_W-1:0] x);
    logic [NODE_W:0] t;
    t = low_zero(x);
    if (t[0]) return x;
    return x ^ (t[NODE_W:1] | t[NODE_W-1:0]);
  endfunction

  // parent in the full tree
  function automatic logic [NODE_W-1:0] step_up(input logic [NODE_W-1:0] x);
    logic [NODE_W:0]   t;
    logic [NODE_W-1:0] t2;
    logic              b;
    t  = low_zero(x);
    t2 = {t[NODE_W-2:0], 1'b0};
    b  = |(x & t2);
    return (x | t[NODE_W-1:0]) ^ (b ? t2 : '0);
  endfunction

  // root is the largest 2^k - 1 below the width
  function automatic logic [NODE_W-1:0] tree_root(input logic [NODE_W-1:0] w);
    logic [NODE_W-1:0] s;
    s = w;
    for (int sh = 1; sh < NODE_W; sh = sh * 2) begin
      s = s | (s >> sh);
    end
    return s >> 1;
  endfunction

  // width 2n-1 from the written leaf count, clamped to 1..LEAF_CAP
  function automatic logic [NODE_W-1:0] tree_width(input logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] n;
    logic [NODE_W-1:0] n_m1;
    if (v == '0) n = NODE_W'(1);
    else if (v > LEAF_CAP) n = LEAF_CAP;
    else n = v;
    n_m1 = n - 1'b1;
    return {n_m1[NODE_W-2:0], 1'b1};
  endfunction

endpackage

@@ design/lbtm_datapath.sv @@
// datapath: tree width register, node working registers, result register
// depends on lbtm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbtm_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [2:0]                   in_op,
  input  logic [lbtm_pkg::NODE_W-1:0]  in_node_index,
  input  logic                         cfg_we,
  input  logic [lbtm_pkg::NODE_W-1:0]  cfg_leaf_count,
  input  lbtm_pkg::dp_cmd_t            cmd,
  output lbtm_pkg::dp_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lbtm_pkg::NODE_W-1:0]  out_result_value,
  output logic                         out_last,
  output logic                         out_empty_res,
  output logic                         out_out_of_range
);

  lbtm_pkg::op_t               op_r, op_nxt;
  logic [lbtm_pkg::NODE_W-1:0] w_r, w_nxt;
  logic [lbtm_pkg::NODE_W-1:0] x_r, x_nxt;
  logic [lbtm_pkg::NODE_W-1:0] p_r, p_nxt;
  logic [lbtm_pkg::NODE_W-1:0] s_r, s_nxt;
  logic [lbtm_pkg::NODE_W-1:0] root_c;
  logic [lbtm_pkg::NODE_W-1:0] val_c;

  logic                        out_valid_r, out_valid_nxt;
  logic [lbtm_pkg::NODE_W-1:0] out_value_r, out_value_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_empty_r, out_empty_nxt;
  logic                        out_oor_r, out_oor_nxt;

  assign root_c = lbtm_pkg::tree_root(w_r);

  // status toward the controller
  always_comb begin
    stat.op        = op_r;
    stat.x_oor     = (x_r >= w_r);
    stat.x_is_root = (x_r == root_c);
    stat.p_ge_w    = (p_r >= w_r);
    stat.p_is_root = (p_r == root_c);
    stat.s_ge_w    = (s_r >= w_r);
    stat.out_busy  = out_valid_r & out_stall;
  end

  // width register, loaded by a config beat
  assign w_nxt = cfg_we ? lbtm_pkg::tree_width(cfg_leaf_count) : w_r;

  // request and walk registers
  always_comb begin
    op_nxt = op_r;
    x_nxt  = x_r;
    if (cmd.load) begin
      op_nxt = lbtm_pkg::op_t'(in_op);
      x_nxt  = in_node_index;
    end else if (cmd.x_from_p) begin
      x_nxt = p_r;
    end
  end

  // parent register: steps up, repaired while beyond the width
  always_comb begin
    case (cmd.p_op)
      lbtm_pkg::P_UP_X:  p_nxt = lbtm_pkg::step_up(x_r);
      lbtm_pkg::P_SET_X: p_nxt = x_r;
      lbtm_pkg::P_UP_P:  p_nxt = lbtm_pkg::step_up(p_r);
      default:           p_nxt = p_r;
    endcase
  end

  // sibling / right child register: descends left while beyond the width
  always_comb begin
    case (cmd.s_op)
      lbtm_pkg::S_SIB:
        s_nxt = (x_r < p_r) ? lbtm_pkg::raw_right(p_r) : lbtm_pkg::left_of(p_r);
      lbtm_pkg::S_RIGHT_X: s_nxt = lbtm_pkg::raw_right(x_r);
      lbtm_pkg::S_LEFT:    s_nxt = lbtm_pkg::left_of(s_r);
      default:             s_nxt = s_r;
    endcase
  end

  // result value select
  always_comb begin
    case (cmd.vsel)
      lbtm_pkg::V_ROOT:  val_c = root_c;
      lbtm_pkg::V_LEVEL: val_c = lbtm_pkg::level_of(x_r);
      lbtm_pkg::V_LEFT:  val_c = lbtm_pkg::left_of(x_r);
      lbtm_pkg::V_P:     val_c = p_r;
      lbtm_pkg::V_S:     val_c = s_r;
      default:           val_c = '0;
    endcase
  end

  // output register: holds a beat until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_oor_nxt   = out_oor_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = val_c;
      out_last_nxt  = cmd.last;
      out_empty_nxt = cmd.empty;
      out_oor_nxt   = cmd.oor;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= lbtm_pkg::NODE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    x_r         <= x_nxt;
    p_r         <= p_nxt;
    s_r         <= s_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_last         = out_last_r;
  assign out_empty_res    = out_empty_r;
  assign out_out_of_range = out_oor_r;

  `A_ALWAYS(a_root_in_tree, clk, rst_n, root_c < w_r)
  `A_IMPLIES(a_empty_is_last, clk, rst_n, out_valid_r && out_empty_r, out_last_r)
  `A_IMPLIES(a_oor_zero_last, clk, rst_n, out_valid_r && out_oor_r, out_value_r == '0 && out_last_r)

endmodule

@@ design/lbtm_ctrl.sv @@
// controller: sequences decode, parent repair and sibling repair steps
// depends on lbtm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbtm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               cfg_ready,
  input  lbtm_pkg::dp_stat_t stat,
  output lbtm_pkg::dp_cmd_t  cmd
);

  lbtm_pkg::state_t state_r, state_nxt;
  logic             in_accept;

  assign in_stall  = (state_r != lbtm_pkg::ST_IDLE);
  assign cfg_ready = (state_r == lbtm_pkg::ST_IDLE);
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbtm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.x_from_p = 1'b0;
    cmd.p_op     = lbtm_pkg::P_HOLD;
    cmd.s_op     = lbtm_pkg::S_HOLD;
    cmd.emit     = 1'b0;
    cmd.vsel     = lbtm_pkg::V_ZERO;
    cmd.last     = 1'b1;
    cmd.empty    = 1'b0;
    cmd.oor      = 1'b0;
    case (state_r)
      lbtm_pkg::ST_IDLE: begin
        if (in_accept) begin
          cmd.load  = 1'b1;
          state_nxt = lbtm_pkg::ST_DECODE;
        end
      end
      lbtm_pkg::ST_DECODE: begin
        if (stat.op == lbtm_pkg::OP_ROOT) begin
          cmd.vsel = lbtm_pkg::V_ROOT;
          if (!stat.out_busy) begin
            cmd.emit  = 1'b1;
            state_nxt = lbtm_pkg::ST_IDLE;
          end
        end else if (stat.x_oor) begin
          cmd.vsel = lbtm_pkg::V_ZERO;
          cmd.oor  = 1'b1;
          if (!stat.out_busy) begin
            cmd.emit  = 1'b1;
            state_nxt = lbtm_pkg::ST_IDLE;
          end
        end else begin
          case (stat.op)
            lbtm_pkg::OP_LEVEL, lbtm_pkg::OP_LEFT: begin
              cmd.vsel = (stat.op == lbtm_pkg::OP_LEVEL) ? lbtm_pkg::V_LEVEL
                                                         : lbtm_pkg::V_LEFT;
              if (!stat.out_busy) begin
                cmd.emit  = 1'b1;
                state_nxt = lbtm_pkg::ST_IDLE;
              end
            end
            lbtm_pkg::OP_RIGHT: begin
              cmd.s_op  = lbtm_pkg::S_RIGHT_X;
              state_nxt = lbtm_pkg::ST_SFIX;
            end
            lbtm_pkg::OP_PARENT, lbtm_pkg::OP_SIBLING: begin
              cmd.p_op  = stat.x_is_root ? lbtm_pkg::P_SET_X : lbtm_pkg::P_UP_X;
              state_nxt = lbtm_pkg::ST_PFIX;
            end
            lbtm_pkg::OP_PATH, lbtm_pkg::OP_COPATH: begin
              // path of the root is one empty beat
              if (stat.x_is_root) begin
                cmd.vsel  = lbtm_pkg::V_ZERO;
                cmd.empty = 1'b1;
                if (!stat.out_busy) begin
                  cmd.emit  = 1'b1;
                  state_nxt = lbtm_pkg::ST_IDLE;
                end
              end else begin
                cmd.p_op  = lbtm_pkg::P_UP_X;
                state_nxt = lbtm_pkg::ST_PFIX;
              end
            end
            default: state_nxt = lbtm_pkg::ST_IDLE;
          endcase
        end
      end
      lbtm_pkg::ST_PFIX: begin
        cmd.vsel = lbtm_pkg::V_P;
        if (stat.p_ge_w) begin
          cmd.p_op = lbtm_pkg::P_UP_P;
        end else begin
          case (stat.op)
            lbtm_pkg::OP_PARENT: begin
              if (!stat.out_busy) begin
                cmd.emit  = 1'b1;
                state_nxt = lbtm_pkg::ST_IDLE;
              end
            end
            lbtm_pkg::OP_PATH: begin
              cmd.last = stat.p_is_root;
              if (!stat.out_busy) begin
                cmd.emit     = 1'b1;
                cmd.x_from_p = 1'b1;
                if (stat.p_is_root) begin
                  state_nxt = lbtm_pkg::ST_IDLE;
                end else begin
                  cmd.p_op = lbtm_pkg::P_UP_P;
                end
              end
            end
            lbtm_pkg::OP_SIBLING, lbtm_pkg::OP_COPATH: begin
              cmd.s_op  = lbtm_pkg::S_SIB;
              state_nxt = lbtm_pkg::ST_SFIX;
            end
            default: state_nxt = lbtm_pkg::ST_IDLE;
          endcase
        end
      end
      lbtm_pkg::ST_SFIX: begin
        cmd.vsel = lbtm_pkg::V_S;
        if (stat.s_ge_w) begin
          cmd.s_op = lbtm_pkg::S_LEFT;
        end else if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          if (stat.op == lbtm_pkg::OP_COPATH) begin
            cmd.last     = stat.p_is_root;
            cmd.x_from_p = 1'b1;
            if (stat.p_is_root) begin
              state_nxt = lbtm_pkg::ST_IDLE;
            end else begin
              cmd.p_op  = lbtm_pkg::P_UP_P;
              state_nxt = lbtm_pkg::ST_PFIX;
            end
          end else begin
            state_nxt = lbtm_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = lbtm_pkg::ST_IDLE;
    endcase
  end

  `A_NEXT(a_accept_decode, clk, rst_n, in_accept, state_r == lbtm_pkg::ST_DECODE)
  `A_IMPLIES(a_load_in_idle, clk, rst_n, cmd.load, state_r == lbtm_pkg::ST_IDLE)
  `A_IMPLIES(a_emit_when_free, clk, rst_n, cmd.emit, !stat.out_busy)

endmodule

@@ design/left_balanced_tree_index_math_unit.sv @@
// level, left, root, out-of-range and empty path results come straight from decode;
// parent and path go through parent repair, right through sibling repair, sibling and
// copath through both; one request at a time: the input stalls until the last result
// of a request is loaded; a path or copath gives one result per ancestor step, up to 16;
// a stalled beat holds in the output register and further results wait for it
// reset: one leaf (width 1, root 0), controller idle, no result pending
// top level: joins the controller and the datapath
// depends on lbtm_pkg, lbtm_ctrl and lbtm_datapath
`timescale 1ns / 1ps

module left_balanced_tree_index_math_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_op,
  input  logic [lbtm_pkg::NODE_W-1:0]  in_node_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lbtm_pkg::NODE_W-1:0]  out_result_value,
  output logic                         out_last,
  output logic                         out_empty_res,
  output logic                         out_out_of_range,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lbtm_pkg::NODE_W-1:0]  cfg_leaf_count
);

  lbtm_pkg::dp_cmd_t  cmd;
  lbtm_pkg::dp_stat_t stat;
  logic               cfg_we;

  // config beat
  assign cfg_we = cfg_valid & cfg_ready;

  lbtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lbtm_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_node_index    (in_node_index),
    .cfg_we           (cfg_we),
    .cfg_leaf_count   (cfg_leaf_count),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_last         (out_last),
    .out_empty_res    (out_empty_res),
    .out_out_of_range (out_out_of_range)
  );

endmodule

@@ tb/tb_top.sv @@
// self-checking bench for the left-balanced tree index math unit: a built-in predictor
// computes every result beat, and a monitor checks each one in order; needs lbtm_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int NODE_W      = lbtm_pkg::NODE_W;
  localparam int LEAF_BITS   = lbtm_pkg::LEAF_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_WALK    = 16;
  localparam int LAST_INDEX  = (1 << NODE_W) - 1;

  typedef struct packed {
    logic [NODE_W-1:0] value;
    logic              last;
    logic              empty;
    logic              oor;
  } beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  lbtm_pkg::op_t     in_op = lbtm_pkg::OP_LEVEL;
  logic [NODE_W-1:0] in_node_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NODE_W-1:0] out_result_value;
  logic              out_last;
  logic              out_empty_res;
  logic              out_out_of_range;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [NODE_W-1:0] cfg_leaf_count = '0;

  // tree shape as last written, plus the beats still owed by the block
  logic [NODE_W-1:0] tree_leaves = NODE_W'(1);
  beat_t             owed_beats[$];
  int                mismatches = 0;
  int                cycle_count = 0;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  logic              rx_hold = 1'b0;

  left_balanced_tree_index_math_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_node_index    (in_node_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_last         (out_last),
    .out_empty_res    (out_empty_res),
    .out_out_of_range (out_out_of_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_leaf_count   (cfg_leaf_count)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- tree math

  // width 2n-1 with the leaf count clamped to 1..cap
  function automatic int unsigned tree_span();
    int unsigned n;
    int unsigned cap;
    cap = (LEAF_BITS >= 16) ? 65536 : (1 << LEAF_BITS);
    n   = tree_leaves;
    if (n < 1) n = 1;
    if (n > cap) n = cap;
    return 2 * n - 1;
  endfunction

  function automatic int unsigned root_node();
    int unsigned w;
    int unsigned p;
    w = tree_span();
    p = 1;
    while ((p << 1) <= w) p = p << 1;
    return p - 1;
  endfunction

  // count of trailing ones
  function automatic int unsigned level_at(int unsigned x);
    int unsigned k;
    k = 0;
    while (k < 40 && ((x >> k) & 1) == 1) k++;
    return k;
  endfunction

  function automatic int unsigned left_child(int unsigned x);
    int unsigned k;
    k = level_at(x);
    if (k == 0) return x;
    return x ^ (1 << (k - 1));
  endfunction

  // right child, walking left while it falls past the width
  function automatic int unsigned right_child(int unsigned x);
    int unsigned k;
    int unsigned w;
    int unsigned r;
    k = level_at(x);
    w = tree_span();
    if (k == 0) return x;
    r = x ^ (3 << (k - 1));
    for (int i = 0; i < 64 && r >= w; i++) r = left_child(r);
    return r;
  endfunction

  // parent in the unbounded full tree
  function automatic int unsigned full_parent(int unsigned x);
    int unsigned k;
    int unsigned b;
    k = level_at(x);
    b = (x >> (k + 1)) & 1;
    return (x | (1 << k)) ^ (b << (k + 1));
  endfunction

  // parent, climbing again while the step lands past the width
  function automatic int unsigned parent_node(int unsigned x);
    int unsigned r;
    int unsigned w;
    int unsigned p;
    r = root_node();
    w = tree_span();
    if (x == r) return r;
    p = full_parent(x);
    for (int i = 0; i < 64 && p >= w; i++) p = full_parent(p);
    return p;
  endfunction

  function automatic int unsigned sibling_node(int unsigned x);
    int unsigned p;
    p = parent_node(x);
    if (x < p) return right_child(p);
    return left_child(p);
  endfunction

  function automatic void owe_beat(int unsigned v, logic last, logic empty, logic oor);
    beat_t b;
    b.value = NODE_W'(v);
    b.last  = last;
    b.empty = empty;
    b.oor   = oor;
    owed_beats.push_back(b);
  endfunction

  // all beats one request produces
  function automatic void predict_request(lbtm_pkg::op_t op, logic [NODE_W-1:0] idx);
    int unsigned x;
    int unsigned r;
    int unsigned cur;
    int unsigned nxt;
    int unsigned v;
    int          cnt;
    x = idx;
    r = root_node();
    if (op == lbtm_pkg::OP_ROOT) begin
      owe_beat(r, 1'b1, 1'b0, 1'b0);
      return;
    end
    if (x >= tree_span()) begin
      owe_beat(0, 1'b1, 1'b0, 1'b1);
      return;
    end
    case (op)
      lbtm_pkg::OP_LEVEL: begin
        owe_beat(level_at(x), 1'b1, 1'b0, 1'b0);
        return;
      end
      lbtm_pkg::OP_LEFT: begin
        owe_beat(left_child(x), 1'b1, 1'b0, 1'b0);
        return;
      end
      lbtm_pkg::OP_RIGHT: begin
        owe_beat(right_child(x), 1'b1, 1'b0, 1'b0);
        return;
      end
      lbtm_pkg::OP_PARENT: begin
        owe_beat(parent_node(x), 1'b1, 1'b0, 1'b0);
        return;
      end
      lbtm_pkg::OP_SIBLING: begin
        owe_beat(sibling_node(x), 1'b1, 1'b0, 1'b0);
        return;
      end
      default: ;
    endcase
    // path of the root has no entries
    if (x == r) begin
      owe_beat(0, 1'b1, 1'b1, 1'b0);
      return;
    end
    cur = x;
    cnt = 0;
    while (cur != r && cnt < MAX_WALK) begin
      nxt = parent_node(cur);
      v   = (op == lbtm_pkg::OP_PATH) ? nxt : sibling_node(cur);
      cur = nxt;
      owe_beat(v, (cur == r) || (cnt + 1 == MAX_WALK), 1'b0, 1'b0);
      cnt++;
    end
  endfunction

  // ---------------------------------------------------------------- receiver side

  // random stall, forced high during a hold-off
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
  end

  // compare each result beat with the oldest owed beat
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.value = out_result_value;
      got.last  = out_last;
      got.empty = out_empty_res;
      got.oor   = out_out_of_range;
      if (owed_beats.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat value=%0d last=%b empty=%b oor=%b", $time,
                 got.value, got.last, got.empty, got.oor);
      end else begin
        want = owed_beats.pop_front();
        if (got.value !== want.value || got.last !== want.last ||
            got.empty !== want.empty || got.oor !== want.oor) begin
          mismatches++;
          $display("%0t: mismatch expected value=%0d last=%b empty=%b oor=%b", $time,
                   want.value, want.last, want.empty, want.oor);
          $display("%0t:          actual   value=%0d last=%b empty=%b oor=%b", $time,
                   got.value, got.last, got.empty, got.oor);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sender side

  // offer one request, maybe after idle cycles, and hold it until taken
  task automatic send_req(lbtm_pkg::op_t op, logic [NODE_W-1:0] idx);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_node_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, idx);
  endtask

  // stop offering and wait until every owed beat has arrived
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_leaf_count(logic [NODE_W-1:0] v);
    drain();
    cfg_valid      <= 1'b1;
    cfg_leaf_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    tree_leaves = v;
  endtask

  // random index: mostly inside the tree, some edges, leaves and out-of-range
  function automatic logic [NODE_W-1:0] pick_index();
    int unsigned w;
    int unsigned sel;
    w   = tree_span();
    sel = $urandom_range(0, 99);
    if (sel < 70) return NODE_W'($urandom_range(0, w - 1));
    if (sel < 80) return NODE_W'(2 * $urandom_range(0, (w - 1) / 2));
    if (sel < 85) return NODE_W'(w - 1);
    if (sel < 90) return NODE_W'(root_node());
    return NODE_W'($urandom_range(w, LAST_INDEX));
  endfunction

  function automatic logic [NODE_W-1:0] pick_leaf_count();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return NODE_W'($urandom_range(1, 24));
    if (sel < 8) return NODE_W'($urandom_range(25, 65536));
    if (sel == 8) return NODE_W'(65536);
    if ($urandom_range(0, 1) == 0) return '0;
    return NODE_W'($urandom_range(65537, LAST_INDEX));
  endfunction

  // ---------------------------------------------------------------- tests

  // reset state: one leaf, every op on the lone node
  task automatic test_single_leaf();
    for (int i = 0; i < 8; i++) send_req(lbtm_pkg::op_t'(i), '0);
    drain();
  endtask

  // five leaves: both repairs, leaf children, root corner cases, width edge
  task automatic test_repairs();
    write_leaf_count(NODE_W'(5));
    send_req(lbtm_pkg::OP_RIGHT, NODE_W'(7));
    send_req(lbtm_pkg::OP_RIGHT, NODE_W'(3));
    send_req(lbtm_pkg::OP_PARENT, NODE_W'(8));
    send_req(lbtm_pkg::OP_PARENT, NODE_W'(7));
    send_req(lbtm_pkg::OP_SIBLING, NODE_W'(8));
    send_req(lbtm_pkg::OP_SIBLING, NODE_W'(7));
    send_req(lbtm_pkg::OP_LEFT, NODE_W'(2));
    send_req(lbtm_pkg::OP_RIGHT, NODE_W'(4));
    send_req(lbtm_pkg::OP_PATH, NODE_W'(8));
    send_req(lbtm_pkg::OP_COPATH, NODE_W'(8));
    send_req(lbtm_pkg::OP_PATH, NODE_W'(7));
    send_req(lbtm_pkg::OP_COPATH, NODE_W'(7));
    send_req(lbtm_pkg::OP_LEVEL, NODE_W'(8));
    send_req(lbtm_pkg::OP_LEVEL, NODE_W'(9));
    send_req(lbtm_pkg::OP_ROOT, NODE_W'(LAST_INDEX));
    drain();
  endtask

  // leaf count zero and saturated, deepest walks, top index
  task automatic test_size_extremes();
    write_leaf_count('0);
    send_req(lbtm_pkg::OP_ROOT, '0);
    send_req(lbtm_pkg::OP_PARENT, NODE_W'(2));
    write_leaf_count(NODE_W'(LAST_INDEX));
    send_req(lbtm_pkg::OP_PATH, '0);
    send_req(lbtm_pkg::OP_COPATH, NODE_W'(131070));
    send_req(lbtm_pkg::OP_LEVEL, NODE_W'(65535));
    send_req(lbtm_pkg::OP_LEFT, NODE_W'(LAST_INDEX));
    drain();
  endtask

  // random requests over several random tree sizes
  task automatic test_random_mix(int tx_pct, int rx_pct, int phases, int per_phase);
    int unsigned   sel;
    lbtm_pkg::op_t op;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int p = 0; p < phases; p++) begin
      write_leaf_count(pick_leaf_count());
      for (int i = 0; i < per_phase; i++) begin
        sel = $urandom_range(0, 9);
        // lean on the walks, they go deepest
        if (sel < 4) op = ($urandom_range(0, 1) == 0) ? lbtm_pkg::OP_PATH
                                                       : lbtm_pkg::OP_COPATH;
        else op = lbtm_pkg::op_t'($urandom_range(0, 7));
        send_req(op, pick_index());
      end
    end
    drain();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_receiver_hold();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_leaf_count(NODE_W'(1000));
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 24; i++) begin
      send_req((i % 2 == 0) ? lbtm_pkg::OP_PATH : lbtm_pkg::OP_COPATH,
               NODE_W'(2 * $urandom_range(0, 999)));
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_leaf();
    test_repairs();
    test_size_extremes();
    test_random_mix(20, 45, 4, 32);
    test_random_mix(45, 20, 4, 32);
    test_random_mix(0, 0, 4, 32);
    test_receiver_hold();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && owed_beats.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
